// ===== rtl/core/tncrlf_pkg.sv =====
// ============================================================================
// tncrlf_pkg: shared types and constants of the line-ending normalizer
// Beat layouts, byte classes and length helpers used by every module.
// ============================================================================
package tncrlf_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int FIELD_BITS  = 24;
  localparam int CMP_BITS    = (LENGTH_BITS > FIELD_BITS) ? LENGTH_BITS : FIELD_BITS;

  localparam logic [FIELD_BITS-1:0]  FIELD_MAX     = {FIELD_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX     = {LENGTH_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0]  MAX_OUT_RESET = 24'h100000;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Configuration map: three address bits, register index in bit 2.
  localparam int          PADDR_BITS      = 3;
  localparam logic [0:0]  REG_MAX_OUT_IDX = 1'b0;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_NUL   = 2'd1,
    KIND_CR    = 2'd2,
    KIND_LF    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  out_valid;
    logic                  done_res;
    logic                  truncated;
    logic [1:0]            change_count;
    logic [FIELD_BITS-1:0] raw_length;
    logic [FIELD_BITS-1:0] cleaned_length;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } item_t;

  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + LENGTH_BITS'(1);
  endfunction

  function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [LENGTH_BITS-1:0] v);
    logic [CMP_BITS-1:0] w;
    w = CMP_BITS'(v);
    return (w > CMP_BITS'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/tncrlf_front.sv =====
// ============================================================================
// tncrlf_front: input side of the normalizer
// Accepts input beats and tags each byte with its class for the back end.
// ============================================================================
module tncrlf_front (
  input  logic                 push,
  output logic                 full,
  input  tncrlf_pkg::in_beat_t in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output tncrlf_pkg::item_t    q_item
);

  tncrlf_pkg::kind_t kind;

  always_comb begin
    case (in_data.in_byte)
      tncrlf_pkg::CH_NUL: kind = tncrlf_pkg::KIND_NUL;
      tncrlf_pkg::CH_CR:  kind = tncrlf_pkg::KIND_CR;
      tncrlf_pkg::CH_LF:  kind = tncrlf_pkg::KIND_LF;
      default:            kind = tncrlf_pkg::KIND_OTHER;
    endcase
  end

  assign full        = q_full;
  assign q_push      = push && !q_full;
  assign q_item.data = in_data.in_byte;
  assign q_item.kind = kind;
  assign q_item.last = in_data.is_last;

endmodule

// ===== rtl/core/tncrlf_queue.sv =====
// ============================================================================
// tncrlf_queue: two-entry queue of classified bytes
// Decouples the front end from the back end so each can stall on its own.
// ============================================================================
module tncrlf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  tncrlf_pkg::item_t wr_item,
  output logic              full,
  input  logic              rd_en,
  output tncrlf_pkg::item_t rd_item,
  output logic              empty
);

  tncrlf_pkg::item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/tncrlf_back.sv =====
// ============================================================================
// tncrlf_back: string state and result buffer of the normalizer
// Applies CR/LF folding, null dropping and the output limit, then buffers
// result beats in a two-entry queue toward the consumer.
// ============================================================================
module tncrlf_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [tncrlf_pkg::FIELD_BITS-1:0]     max_out_bytes,
  input  logic                                  q_empty,
  input  tncrlf_pkg::item_t                     q_item,
  output logic                                  q_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output tncrlf_pkg::out_beat_t                 out_data
);

  // String state.
  logic                               pending_cr;
  logic                               saw_null;
  logic                               saw_crlf;
  logic                               saw_overflow;
  logic [tncrlf_pkg::LENGTH_BITS-1:0] input_count;
  logic [tncrlf_pkg::LENGTH_BITS-1:0] output_count;

  logic                               pending_cr_next;
  logic                               saw_null_next;
  logic                               saw_crlf_next;
  logic                               saw_overflow_next;
  logic [tncrlf_pkg::LENGTH_BITS-1:0] input_count_next;
  logic [tncrlf_pkg::LENGTH_BITS-1:0] output_count_next;

  logic                  want;
  logic [7:0]            emit;
  logic                  room;
  tncrlf_pkg::out_beat_t res;

  // Result queue.
  tncrlf_pkg::out_beat_t res_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       res_full;
  logic       res_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_pop  = pop && !empty;
  assign q_pop    = !q_empty && !res_full;
  assign out_data = res_q[rd_ptr];

  assign room = tncrlf_pkg::CMP_BITS'(output_count) < tncrlf_pkg::CMP_BITS'(max_out_bytes);

  always_comb begin
    pending_cr_next   = pending_cr;
    saw_null_next     = saw_null;
    saw_crlf_next     = saw_crlf;
    saw_overflow_next = saw_overflow;
    input_count_next  = tncrlf_pkg::sat_inc(input_count);
    output_count_next = output_count;
    want              = 1'b0;
    emit              = q_item.data;

    case (q_item.kind)
      tncrlf_pkg::KIND_NUL: begin
        saw_null_next = 1'b1;
      end
      tncrlf_pkg::KIND_CR: begin
        want            = 1'b1;
        emit            = tncrlf_pkg::CH_LF;
        pending_cr_next = 1'b1;
      end
      tncrlf_pkg::KIND_LF: begin
        if (pending_cr) begin
          saw_crlf_next = 1'b1;
        end else begin
          want = 1'b1;
        end
        pending_cr_next = 1'b0;
      end
      default: begin
        want            = 1'b1;
        pending_cr_next = 1'b0;
      end
    endcase

    res = '0;
    if (want) begin
      if (room) begin
        res.out_valid     = 1'b1;
        res.out_byte      = emit;
        output_count_next = tncrlf_pkg::sat_inc(output_count);
      end else begin
        saw_overflow_next = 1'b1;
      end
    end

    if (q_item.last) begin
      res.done_res        = 1'b1;
      res.truncated       = saw_overflow_next;
      res.change_count    = 2'({1'b0, saw_null_next} + {1'b0, saw_crlf_next}
                                + {1'b0, saw_overflow_next});
      res.raw_length      = tncrlf_pkg::clamp_field(input_count_next);
      res.cleaned_length  = tncrlf_pkg::clamp_field(output_count_next);
      pending_cr_next     = 1'b0;
      saw_null_next       = 1'b0;
      saw_crlf_next       = 1'b0;
      saw_overflow_next   = 1'b0;
      input_count_next    = '0;
      output_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cr   <= 1'b0;
      saw_null     <= 1'b0;
      saw_crlf     <= 1'b0;
      saw_overflow <= 1'b0;
      input_count  <= '0;
      output_count <= '0;
    end else if (q_pop) begin
      pending_cr   <= pending_cr_next;
      saw_null     <= saw_null_next;
      saw_crlf     <= saw_crlf_next;
      saw_overflow <= saw_overflow_next;
      input_count  <= input_count_next;
      output_count <= output_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_pop) begin
        wr_ptr <= ~wr_ptr;
      end
      if (res_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({q_pop, res_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/text_null_strip_crlf_normalizer_top.sv =====
// ============================================================================
// text_null_strip_crlf_normalizer_top: text line-ending normalizer
// Drops zero bytes, folds CR and CRLF into LF, limits the output length and
// reports a per-string summary on the beat of the last byte.
// ============================================================================
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------------
//   input     push / full            in_data  (in_byte, is_last)
//   result    empty / pop            out_data (byte, valid, summary)
//   config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One byte enters per cycle while full is low, and one result beat leaves
// per cycle while empty is low. A byte passes through the classified-byte
// queue and then the result queue before its result is visible on out_data.
// The back end updates the CR flag and the length counters for every byte
// it pops from the byte queue. Reset (rst, synchronous) empties both queues,
// clears the string state and loads max_out_bytes with 1048576. When the
// consumer stalls, the result queue fills, the back end stops, and full rises
// once the byte queue holds two entries.
//
module text_null_strip_crlf_normalizer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  tncrlf_pkg::in_beat_t                 in_data,
  output logic                                 empty,
  input  logic                                 pop,
  output tncrlf_pkg::out_beat_t                out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tncrlf_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  // Configuration register. Bit 2 of the address selects the register; the
  // byte offset bits are ignored.
  logic [tncrlf_pkg::FIELD_BITS-1:0] max_out_bytes;
  logic                              cfg_wr;
  logic                              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == tncrlf_pkg::REG_MAX_OUT_IDX);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? 32'(max_out_bytes) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_bytes <= tncrlf_pkg::MAX_OUT_RESET;
    end else if (cfg_wr) begin
      max_out_bytes <= pwdata[tncrlf_pkg::FIELD_BITS-1:0];
    end
  end

  // Front end: classify each accepted byte and hand it to the queue.
  logic              q_full;
  logic              q_push;
  tncrlf_pkg::item_t q_wr_item;
  logic              q_pop;
  logic              q_empty;
  tncrlf_pkg::item_t q_rd_item;

  tncrlf_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_wr_item)
  );

  tncrlf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  // Back end: per-string state and the result queue toward the consumer.
  tncrlf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_out_bytes (max_out_bytes),
    .q_empty       (q_empty),
    .q_item        (q_rd_item),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_data      (out_data)
  );

endmodule
